// ===== rtl/core/fdds_pkg.sv =====
package fdds_pkg;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned VALUE_W     = 14;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned BYTE_W      = 8;

  localparam logic [DIGIT_W-1:0] DARK_CODE = 4'hF;
  localparam logic [VALUE_W-1:0] MAX_SHOWN = 14'd9999;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [DIGIT_COUNT-1:0] digit_arr_t;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_BLANK  = 2'd2
  } kind_e;

  // one item leaving the input register towards the scan logic
  typedef struct packed {
    logic               fire;
    kind_e              kind;
    logic [VALUE_W-1:0] value;
  } step_t;

  typedef struct packed {
    logic [BYTE_W-1:0] drive_byte;
    logic [IDX_W-1:0]  digit_index;
  } result_t;

endpackage

// ===== rtl/core/fdds_if.sv =====
interface fdds_in_if import fdds_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [VALUE_W-1:0] shown_value;

  modport source (output valid, output kind, output shown_value, input ready);
  modport sink   (input valid, input kind, input shown_value, output ready);
endinterface

interface fdds_out_if import fdds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] drive_byte;
  logic [IDX_W-1:0]  digit_index;

  modport source (output valid, output drive_byte, output digit_index, input ready);
  modport sink   (input valid, input drive_byte, input digit_index, output ready);
endinterface

// ===== rtl/core/fdds_digit_conv.sv =====
module fdds_digit_conv import fdds_pkg::*; (
  input  logic [VALUE_W-1:0] value_i,
  output digit_arr_t         digits_o
);

  // reciprocal constants, exact for values up to 9999
  localparam logic [27:0] RECIP_1000 = 28'd8389;  // 2^-23
  localparam logic [27:0] RECIP_100  = 28'd5243;  // 2^-19
  localparam logic [27:0] RECIP_10   = 28'd6554;  // 2^-16

  logic [VALUE_W-1:0] sat;
  logic [27:0]        p1000, p100, p10;
  logic [3:0]         th;
  logic [6:0]         q100, th7, hu7;
  logic [9:0]         q10, q100w, te10;
  logic [VALUE_W-1:0] q10w, un14;
  digit_t             th_d, hu_d, te_d;

  always_comb begin
    sat   = (value_i > MAX_SHOWN) ? MAX_SHOWN : value_i;
    p1000 = 28'(sat) * RECIP_1000;
    p100  = 28'(sat) * RECIP_100;
    p10   = 28'(sat) * RECIP_10;
    th    = p1000[26:23];
    q100  = p100[25:19];
    q10   = p10[25:16];

    // remainders via times-ten as shift-add
    th7   = {3'b000, th};
    hu7   = q100 - ((th7 << 3) + (th7 << 1));
    q100w = {3'b000, q100};
    te10  = q10 - ((q100w << 3) + (q100w << 1));
    q10w  = {4'b0000, q10};
    un14  = sat - ((q10w << 3) + (q10w << 1));

    // leading-zero blanking, units always shown
    th_d = (th == 4'd0) ? DARK_CODE : th;
    hu_d = (hu7[3:0] == 4'd0 && th_d == DARK_CODE) ? DARK_CODE : hu7[3:0];
    te_d = (te10[3:0] == 4'd0 && hu_d == DARK_CODE) ? DARK_CODE : te10[3:0];

    digits_o[0] = th_d;
    digits_o[1] = hu_d;
    digits_o[2] = te_d;
    digits_o[3] = un14[3:0];
  end

endmodule

// ===== rtl/core/fdds_scan.sv =====
module fdds_scan import fdds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  step_t   step_i,
  output result_t result_o
);

  localparam logic [IDX_W:0] POS_RESET = '1;

  logic [IDX_W:0] pos_q, pos_d, pos_inc;
  digit_arr_t     store_q, store_d;
  digit_arr_t     pend_q, pend_d;
  digit_arr_t     conv_digits;
  digit_arr_t     dark_digits;
  digit_arr_t     zero_digits;
  logic           reload;
  logic [IDX_W-1:0] pos_new;
  digit_t         digit;
  logic [DIGIT_COUNT-1:0] enable;

  fdds_digit_conv u_conv (
    .value_i  (step_i.value),
    .digits_o (conv_digits)
  );

  fdds_digit_conv u_conv_zero (
    .value_i  ('0),
    .digits_o (zero_digits)
  );

  always_comb begin
    dark_digits = {DIGIT_COUNT{DARK_CODE}};
    pos_inc     = pos_q + 1'b1;
    reload      = pos_inc[IDX_W];
    pos_new     = reload ? '0 : pos_inc[IDX_W-1:0];
    digit       = reload ? pend_q[0] : store_q[pos_new];
    enable      = DIGIT_COUNT'(1) << pos_new;

    result_o.drive_byte  = {enable, digit};
    result_o.digit_index = pos_new;

    pos_d   = pos_q;
    store_d = store_q;
    pend_d  = pend_q;
    if (step_i.fire) begin
      unique case (step_i.kind)
        KIND_TICK: begin
          pos_d = {1'b0, pos_new};
          if (reload) begin
            store_d = pend_q;
          end
        end
        KIND_UPDATE: pend_d = conv_digits;
        KIND_BLANK:  pend_d = dark_digits;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_RESET;
      store_q <= '0;
      pend_q  <= zero_digits;
    end else begin
      pos_q   <= pos_d;
      store_q <= store_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ===== rtl/core/four_digit_display_scanner_core.sv =====
// four-digit multiplexed display scanner. each input beat carries a kind: an
// update stores a value to show (above 9999 it shows 9999) and clears
// blanking, a blank makes the display dark, and a tick lights the next digit
// and gives one output beat: drive_byte holds a one-hot digit enable in its
// upper nibble (bit 4 is the thousands digit) and the bcd digit in its lower
// nibble, 15 meaning dark. new values and blanking only show from the tick
// that lights the thousands digit after the units digit; until then the
// digits show zeros after reset. the block takes one beat per clock: an input
// register feeds one short combinational pass (reciprocal multiply digit
// split, scan position step) into an output register. the only stall is a
// tick meeting a full output register that the sink does not take; update,
// blank and the unused kind move on regardless and give no output beat
module four_digit_display_scanner_core import fdds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fdds_in_if.sink   in_i,
  fdds_out_if.source out_o
);

  // input register
  logic               in_valid_q;
  kind_e              in_kind_q;
  logic [VALUE_W-1:0] in_value_q;

  // output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [IDX_W-1:0]  out_index_q;

  logic    is_tick;
  logic    advance;
  logic    in_take;
  step_t   step;
  result_t result;

  // a tick may only move on when the output register has room this edge
  assign is_tick  = (in_kind_q == KIND_TICK);
  assign advance  = in_valid_q && (!is_tick || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  assign step.fire  = advance;
  assign step.kind  = in_kind_q;
  assign step.value = in_value_q;

  fdds_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q  <= kind_e'(in_i.kind);
      in_value_q <= in_i.shown_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_tick) begin
      out_byte_q  <= result.drive_byte;
      out_index_q <= result.digit_index;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_byte  = out_byte_q;
  assign out_o.digit_index = out_index_q;

  // enable nibble always agrees with the digit index
  a_enable_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.drive_byte[7:4] == (4'b0001 << out_o.digit_index))
    else $error("digit enable does not match digit index");

  // a fresh output beat only comes from a tick that moved on
  a_output_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(advance && is_tick))
    else $error("output beat without a tick");

  // a held input beat is neither dropped nor altered
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_kind_q) && $stable(in_value_q)))
    else $error("stalled input beat lost");

endmodule
